@@ design/look_at_view_matrix_macros.svh @@
// ---------------------------------------------------------------------------
// look_at_view_matrix assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication
`define LAV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LAV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lav_pkg.sv @@
// ---------------------------------------------------------------------------
// lav_pkg
// Widths, stage counts, shared types and rounding helpers of the view
// matrix pipeline.
// ---------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS = 16;

  // unit vector component: range -2^FRAC_BITS .. 2^FRAC_BITS
  localparam int N_W    = FRAC_BITS + 2;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int V_W    = N_W + 1;
  // eye/up times unit component, and the cross product of up and n
  localparam int PN_W   = 32 + N_W;
  localparam int CR_W   = PN_W + 1;
  localparam int UNIT_W = CR_W;
  localparam int PI_W   = $clog2(UNIT_W);
  // the largest normalized magnitude lies in [2^29, 2^30)
  localparam int M_W    = 30;
  localparam int SQR_W  = 2 * M_W;
  localparam int SQ_W   = 64;
  localparam int RT_W   = SQ_W / 2;
  localparam int REM_W  = RT_W + 3;
  localparam int SQ_ST  = SQ_W / 4;
  localparam int NUM_W  = M_W + FRAC_BITS + 1;
  localparam int DR_W   = RT_W + 2;
  localparam int DIV_ST = (Q_W + 1) / 2;
  localparam int UNIT_LAT = 5 + SQ_ST + 1 + DIV_ST + 1;
  // n cross u, and the dot products with the eye point
  localparam int VP_W   = 2 * N_W;
  localparam int VC_W   = VP_W + 1;
  localparam int EV_W   = 32 + V_W;
  localparam int D_W    = EV_W + 2;
  localparam int DX_W   = D_W + 1;

  // row codes
  localparam logic [1:0] ROW_U    = 2'd0;
  localparam logic [1:0] ROW_V    = 2'd1;
  localparam logic [1:0] ROW_N    = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [31:0]       fx_t;
  typedef logic signed [N_W-1:0]    nv_t;
  typedef logic signed [V_W-1:0]    vv_t;
  typedef logic signed [UNIT_W-1:0] uv_t;
  typedef logic [M_W-1:0]           mag_t;

  // data riding along the square root pipeline
  typedef struct packed {
    mag_t [2:0] mag;
    logic [2:0] neg;
    logic       zero;
  } usid_t;

  // one finished item for the row serializer
  typedef struct packed {
    nv_t [2:0] u;
    vv_t [2:0] v;
    nv_t [2:0] n;
    fx_t [2:0] t;
    logic      deg;
  } rows_t;

  // Round x / 2^FRAC_BITS to nearest, ties away from zero
  function automatic vv_t round_v(input logic signed [VC_W-1:0] x);
    logic [VC_W-1:0] m;
    logic [VC_W-1:0] r;
    logic [V_W-1:0]  rv;
    m  = x[VC_W-1] ? VC_W'(-x) : VC_W'(x);
    r  = (m + (VC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rv = r[V_W-1:0];
    return x[VC_W-1] ? vv_t'(-rv) : vv_t'(rv);
  endfunction

  // Round, negate and saturate a dot product to 32 bits
  function automatic fx_t neg_round_sat(input logic signed [D_W-1:0] x);
    logic [D_W-1:0]         m;
    logic [D_W-1:0]         r;
    logic signed [DX_W-1:0] d;
    m = x[D_W-1] ? D_W'(-x) : D_W'(x);
    r = (m + (D_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    d = x[D_W-1] ? signed'({1'b0, r}) : -signed'({1'b0, r});
    if (d > DX_W'(64'sd2147483647)) begin
      d = DX_W'(64'sd2147483647);
    end else if (d < DX_W'(-64'sd2147483648)) begin
      d = DX_W'(-64'sd2147483648);
    end
    return fx_t'(d[31:0]);
  endfunction

endpackage

@@ design/lav_isqrt.sv @@
// ---------------------------------------------------------------------------
// lav_isqrt
// Pipelined integer square root of a 64-bit radicand, two result bits per
// stage, with a sideband that travels in step with the data.
// ---------------------------------------------------------------------------
module lav_isqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [63:0]           in_rad,
  input  lav_pkg::usid_t        in_side,
  output logic                  out_valid,
  output logic [31:0]           out_root,
  output lav_pkg::usid_t        out_side
);
  import lav_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0]  rad;
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
    usid_t            side;
  } sqs_t;

  sqs_t sq_r   [SQ_ST];
  logic sv_r   [SQ_ST];
  sqs_t sq_nxt [SQ_ST];

  // one digit recurrence stage: two root bits
  for (genvar s = 0; s < SQ_ST; s++) begin : g_stage
    always_comb begin
      sqs_t             t;
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      if (s == 0) begin
        t.rad  = in_rad;
        t.rem  = '0;
        t.root = '0;
        t.side = in_side;
      end else begin
        t = sq_r[(s == 0) ? 0 : s - 1];
      end
      for (int j = 0; j < 2; j++) begin
        rem2  = {t.rem[REM_W-3:0], t.rad[SQ_W-1 -: 2]};
        t.rad = t.rad << 2;
        trial = REM_W'({t.root, 2'b01});
        if (rem2 >= trial) begin
          t.rem  = rem2 - trial;
          t.root = {t.root[RT_W-2:0], 1'b1};
        end else begin
          t.rem  = rem2;
          t.root = {t.root[RT_W-2:0], 1'b0};
        end
      end
      sq_nxt[s] = t;
    end

    // advance valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s] <= 1'b0;
      end else if (en) begin
        sv_r[s] <= (s == 0) ? in_valid : sv_r[(s == 0) ? 0 : s - 1];
      end
    end

    // advance payload
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[s] <= sq_nxt[s];
      end
    end
  end

  assign out_valid = sv_r[SQ_ST-1];
  assign out_root  = sq_r[SQ_ST-1].root;
  assign out_side  = sq_r[SQ_ST-1].side;

endmodule

@@ design/lav_unit.sv @@
// ---------------------------------------------------------------------------
// lav_unit
// Normalize a signed 3-vector to unit length in fixed point: magnitude,
// common shift, sum of squares, square root, then a three-lane divider.
// ---------------------------------------------------------------------------
module lav_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  lav_pkg::uv_t [2:0]     in_vec,
  output logic                   out_valid,
  output lav_pkg::nv_t [2:0]     out_vec,
  output logic                   out_zero
);
  import lav_pkg::*;

  localparam logic [PI_W-1:0] MSB_TGT = PI_W'(M_W - 1);

  typedef struct packed {
    logic [RT_W-1:0]       norm;
    logic [2:0][DR_W-1:0]  rem;
    logic [2:0][Q_W-1:0]   low;
    logic [2:0][Q_W-1:0]   quo;
    logic [2:0]            neg;
    logic                  zero;
  } dstg_t;

  logic                    s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [2:0][UNIT_W-1:0]  s1_mag_r, s2_mag_r;
  logic [2:0]              s1_neg_r, s2_neg_r;
  logic                    s2_zero_r, s2_right_r;
  logic [PI_W-1:0]         s2_amt_r;
  usid_t                   s3_side_r, s4_side_r, s5_side_r;
  logic [2:0][SQR_W-1:0]   s4_sq_r;
  logic [SQ_W-1:0]         s5_sum_r;
  logic [UNIT_W-1:0]       any_bits;
  logic [PI_W-1:0]         msb;
  usid_t                   s3_side_nxt;
  logic                    rt_v;
  logic [RT_W-1:0]         rt_root;
  usid_t                   rt_side;
  dstg_t                   dst_r   [DIV_ST+1];
  logic                    dv_r    [DIV_ST+1];
  dstg_t                   dst_nxt [DIV_ST+1];
  logic                    o_v_r;
  logic [2:0][N_W-1:0]     o_vec_r;
  logic                    o_zero_r;

  // stage 1: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_r[i] <= in_vec[i][UNIT_W-1] ? UNIT_W'(-in_vec[i]) : UNIT_W'(in_vec[i]);
        s1_neg_r[i] <= in_vec[i][UNIT_W-1];
      end
    end
  end

  // stage 2: leading one of the largest magnitude and the shift to apply
  always_comb begin
    any_bits = s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
    msb      = '0;
    for (int k = 0; k < UNIT_W; k++) begin
      if (any_bits[k]) begin
        msb = PI_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag_r   <= s1_mag_r;
      s2_neg_r   <= s1_neg_r;
      s2_zero_r  <= (any_bits == '0);
      s2_right_r <= (msb > MSB_TGT);
      s2_amt_r   <= (msb > MSB_TGT) ? msb - MSB_TGT : MSB_TGT - msb;
    end
  end

  // stage 3: shift all three by the common amount
  always_comb begin
    logic [UNIT_W-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = s2_right_r ? (s2_mag_r[i] >> s2_amt_r) : (s2_mag_r[i] << s2_amt_r);
      s3_side_nxt.mag[i] = t[M_W-1:0];
    end
    s3_side_nxt.neg  = s2_neg_r;
    s3_side_nxt.zero = s2_zero_r;
  end

  // stages 3 to 5: shift, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s3_side_nxt;
      for (int i = 0; i < 3; i++) begin
        s4_sq_r[i] <= SQR_W'(s3_side_r.mag[i]) * SQR_W'(s3_side_r.mag[i]);
      end
      s4_side_r <= s3_side_r;
      s5_sum_r  <= SQ_W'(s4_sq_r[0]) + SQ_W'(s4_sq_r[1]) + SQ_W'(s4_sq_r[2]);
      s5_side_r <= s4_side_r;
    end
  end

  // hold valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  lav_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_rad    (s5_sum_r),
    .in_side   (s5_side_r),
    .out_valid (rt_v),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // divider prep: rounded numerator, split into start remainder and low bits
  always_comb begin
    logic [NUM_W-1:0] num;
    dst_nxt[0].norm = rt_root;
    dst_nxt[0].neg  = rt_side.neg;
    dst_nxt[0].zero = rt_side.zero;
    dst_nxt[0].quo  = '0;
    for (int i = 0; i < 3; i++) begin
      num = NUM_W'({rt_side.mag[i], {FRAC_BITS{1'b0}}}) + NUM_W'(rt_root >> 1);
      dst_nxt[0].rem[i] = DR_W'(num[NUM_W-1:Q_W]);
      dst_nxt[0].low[i] = num[Q_W-1:0];
    end
  end

  // divider stages: two quotient bits each, three lanes
  for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
    always_comb begin
      dstg_t t;
      t = dst_r[s-1];
      for (int j = 0; j < 2; j++) begin
        if ((2 * (s - 1) + j) < Q_W) begin
          for (int i = 0; i < 3; i++) begin
            t.rem[i] = {t.rem[i][DR_W-2:0], t.low[i][Q_W-1]};
            t.low[i] = t.low[i] << 1;
            if (t.rem[i] >= DR_W'(t.norm)) begin
              t.rem[i] = t.rem[i] - DR_W'(t.norm);
              t.quo[i] = {t.quo[i][Q_W-2:0], 1'b1};
            end else begin
              t.quo[i] = {t.quo[i][Q_W-2:0], 1'b0};
            end
          end
        end
      end
      dst_nxt[s] = t;
    end
  end

  for (genvar s = 0; s <= DIV_ST; s++) begin : g_dreg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s] <= 1'b0;
      end else if (en) begin
        dv_r[s] <= (s == 0) ? rt_v : dv_r[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dst_r[s] <= dst_nxt[s];
      end
    end
  end

  // output stage: apply signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= dv_r[DIV_ST];
    end
  end

  always_ff @(posedge clk) begin
    logic [N_W-1:0] qe;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qe = N_W'(dst_r[DIV_ST].quo[i]);
        o_vec_r[i] <= dst_r[DIV_ST].neg[i] ? -qe : qe;
      end
      o_zero_r <= dst_r[DIV_ST].zero;
    end
  end

  assign out_valid = o_v_r;
  assign out_zero  = o_zero_r;
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign out_vec[i] = nv_t'(o_vec_r[i]);
  end

endmodule

@@ design/lav_rowser.sv @@
// ---------------------------------------------------------------------------
// lav_rowser
// Row serializer: holds one finished item and hands out its four matrix
// rows, one transaction per cycle, under the receiver's stall.
// ---------------------------------------------------------------------------
module lav_rowser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  lav_pkg::rows_t       in_rows,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_row_index,
  output logic signed [31:0]   out_col_0,
  output logic signed [31:0]   out_col_1,
  output logic signed [31:0]   out_col_2,
  output logic signed [31:0]   out_col_3,
  output logic                 out_last_row,
  output logic                 out_degenerate
);
  import lav_pkg::*;

  localparam fx_t FX_ONE = fx_t'(64'sd1 <<< FRAC_BITS);

  logic        hold_r;
  logic [1:0]  cnt_r;
  rows_t       rows_r;

  // free when empty or when the last row leaves this cycle
  assign take = !hold_r || (!out_stall && (cnt_r == ROW_LAST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      cnt_r  <= ROW_U;
    end else if (take) begin
      hold_r <= in_valid;
      cnt_r  <= ROW_U;
    end else if (!out_stall) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      rows_r <= in_rows;
    end
  end

  // select the current row; degenerate items give zero rows 0 to 2
  always_comb begin
    out_col_0 = '0;
    out_col_1 = '0;
    out_col_2 = '0;
    out_col_3 = '0;
    unique case (cnt_r)
      ROW_U: begin
        out_col_0 = 32'(signed'(rows_r.u[0]));
        out_col_1 = 32'(signed'(rows_r.u[1]));
        out_col_2 = 32'(signed'(rows_r.u[2]));
        out_col_3 = rows_r.t[0];
      end
      ROW_V: begin
        out_col_0 = 32'(signed'(rows_r.v[0]));
        out_col_1 = 32'(signed'(rows_r.v[1]));
        out_col_2 = 32'(signed'(rows_r.v[2]));
        out_col_3 = rows_r.t[1];
      end
      ROW_N: begin
        out_col_0 = 32'(signed'(rows_r.n[0]));
        out_col_1 = 32'(signed'(rows_r.n[1]));
        out_col_2 = 32'(signed'(rows_r.n[2]));
        out_col_3 = rows_r.t[2];
      end
      ROW_LAST: begin
        out_col_3 = FX_ONE;
      end
      default: begin
        out_col_3 = '0;
      end
    endcase
    if (rows_r.deg && (cnt_r != ROW_LAST)) begin
      out_col_0 = '0;
      out_col_1 = '0;
      out_col_2 = '0;
      out_col_3 = '0;
    end
  end

  assign out_valid      = hold_r;
  assign out_row_index  = cnt_r;
  assign out_last_row   = (cnt_r == ROW_LAST);
  assign out_degenerate = rows_r.deg;

endmodule

@@ design/look_at_view_matrix.sv @@
// ---------------------------------------------------------------------------
// look_at_view_matrix
// World-to-view matrix from eye point, reference point and up vector.
// ---------------------------------------------------------------------------
// One input transaction (in_valid high, in_stall low) carries eye, target and
// up in signed Q16.16. The block answers with four row transactions on the
// out_ channel, rows 0 to 3 in order: u, v and n, each with minus its dot
// product with the eye point in col_3, then 0,0,0,1. out_last_row marks row
// 3; out_degenerate is given on all four rows when n or u has zero length,
// and rows 0 to 2 are then zero.
// The four rows of an item follow one per cycle while out_stall is low. The
// whole pipeline advances only when the row serializer at its end is empty or
// hands out its last row, so a new item is taken only then.
// The pipeline runs on one common advance: two normalization units (each
// 32 stages: shift, squares, 16-stage square root, 9-stage divider) with
// cross and dot product stages around them.
// When out_stall is high the held row stays put, the pipeline freezes and
// in_stall rises. Synchronous reset empties every stage; no item survives.
// ---------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_eye_x,
  input  logic signed [31:0]  in_eye_y,
  input  logic signed [31:0]  in_eye_z,
  input  logic signed [31:0]  in_target_x,
  input  logic signed [31:0]  in_target_y,
  input  logic signed [31:0]  in_target_z,
  input  logic signed [31:0]  in_up_x,
  input  logic signed [31:0]  in_up_y,
  input  logic signed [31:0]  in_up_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_row_index,
  output logic signed [31:0]  out_col_0,
  output logic signed [31:0]  out_col_1,
  output logic signed [31:0]  out_col_2,
  output logic signed [31:0]  out_col_3,
  output logic                out_last_row,
  output logic                out_degenerate
);
  import lav_pkg::*;

  typedef struct packed {
    fx_t [2:0] eye;
    fx_t [2:0] up;
  } side1_t;

  typedef struct packed {
    fx_t [2:0] eye;
    nv_t [2:0] n;
    logic      deg;
  } side2_t;

  logic       en;
  fx_t [2:0]  eye_in;
  fx_t [2:0]  tgt_in;
  fx_t [2:0]  up_in;

  // stage A
  logic       a_v_r;
  uv_t [2:0]  a_d_r;
  side1_t     a_side_r;

  // first normalization
  logic       u1_v;
  nv_t [2:0]  u1_vec;
  logic       u1_zero;
  side1_t     d1_r [UNIT_LAT];

  // cross up x n
  logic                     x1_v_r, x2_v_r;
  logic signed [PN_W-1:0]   x1_pa_r [3];
  logic signed [PN_W-1:0]   x1_pb_r [3];
  side2_t                   x1_side_r, x2_side_r;
  uv_t [2:0]                x2_c_r;

  // second normalization
  logic       u2_v;
  nv_t [2:0]  u2_vec;
  logic       u2_zero;
  side2_t     d2_r [UNIT_LAT];

  // back end
  logic                     y1_v_r, y2_v_r, y3_v_r, y4_v_r, y5_v_r;
  logic signed [VP_W-1:0]   y1_va_r [3];
  logic signed [VP_W-1:0]   y1_vb_r [3];
  logic signed [PN_W-1:0]   y1_eu_r [3];
  logic signed [PN_W-1:0]   y1_enp_r [3];
  fx_t [2:0]                y1_eye_r, y2_eye_r;
  nv_t [2:0]                y1_u_r, y2_u_r, y3_u_r, y4_u_r, y5_u_r;
  nv_t [2:0]                y1_n_r, y2_n_r, y3_n_r, y4_n_r, y5_n_r;
  logic                     y1_deg_r, y2_deg_r, y3_deg_r, y4_deg_r, y5_deg_r;
  vv_t [2:0]                y2_vv_r, y3_vv_r, y4_vv_r, y5_vv_r;
  logic signed [D_W-1:0]    y2_du_r, y2_dn_r, y4_dv_r;
  logic signed [EV_W-1:0]   y3_ev_r [3];
  fx_t                      y3_tu_r, y3_tn_r, y4_tu_r, y4_tn_r, y5_tu_r, y5_tn_r;
  fx_t                      y5_tv_r;
  rows_t                    rows;

  assign eye_in = {in_eye_z, in_eye_y, in_eye_x};
  assign tgt_in = {in_target_z, in_target_y, in_target_x};
  assign up_in  = {in_up_z, in_up_y, in_up_x};

  assign in_stall = !en;

  // valid bits of the top-level stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      x1_v_r <= 1'b0;
      x2_v_r <= 1'b0;
      y1_v_r <= 1'b0;
      y2_v_r <= 1'b0;
      y3_v_r <= 1'b0;
      y4_v_r <= 1'b0;
      y5_v_r <= 1'b0;
    end else if (en) begin
      a_v_r  <= in_valid;
      x1_v_r <= u1_v;
      x2_v_r <= x1_v_r;
      y1_v_r <= u2_v;
      y2_v_r <= y1_v_r;
      y3_v_r <= y2_v_r;
      y4_v_r <= y3_v_r;
      y5_v_r <= y4_v_r;
    end
  end

  // stage A: direction eye - target
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_d_r[i] <= UNIT_W'(signed'(eye_in[i])) - UNIT_W'(signed'(tgt_in[i]));
      end
      a_side_r.eye <= eye_in;
      a_side_r.up  <= up_in;
    end
  end

  lav_unit u_unit_n (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_v_r),
    .in_vec    (a_d_r),
    .out_valid (u1_v),
    .out_vec   (u1_vec),
    .out_zero  (u1_zero)
  );

  // delay eye and up alongside the first unit
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= a_side_r;
      for (int k = 1; k < UNIT_LAT; k++) begin
        d1_r[k] <= d1_r[k-1];
      end
    end
  end

  // cross up x n: products, then differences
  always_ff @(posedge clk) begin
    fx_t [2:0] up;
    up = d1_r[UNIT_LAT-1].up;
    if (en) begin
      x1_pa_r[0] <= PN_W'(signed'(up[1])) * PN_W'(signed'(u1_vec[2]));
      x1_pb_r[0] <= PN_W'(signed'(up[2])) * PN_W'(signed'(u1_vec[1]));
      x1_pa_r[1] <= PN_W'(signed'(up[2])) * PN_W'(signed'(u1_vec[0]));
      x1_pb_r[1] <= PN_W'(signed'(up[0])) * PN_W'(signed'(u1_vec[2]));
      x1_pa_r[2] <= PN_W'(signed'(up[0])) * PN_W'(signed'(u1_vec[1]));
      x1_pb_r[2] <= PN_W'(signed'(up[1])) * PN_W'(signed'(u1_vec[0]));
      x1_side_r.eye <= d1_r[UNIT_LAT-1].eye;
      x1_side_r.n   <= u1_vec;
      x1_side_r.deg <= u1_zero;
      for (int i = 0; i < 3; i++) begin
        x2_c_r[i] <= CR_W'(x1_pa_r[i]) - CR_W'(x1_pb_r[i]);
      end
      x2_side_r <= x1_side_r;
    end
  end

  lav_unit u_unit_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x2_v_r),
    .in_vec    (x2_c_r),
    .out_valid (u2_v),
    .out_vec   (u2_vec),
    .out_zero  (u2_zero)
  );

  // delay eye, n and the first flag alongside the second unit
  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0] <= x2_side_r;
      for (int k = 1; k < UNIT_LAT; k++) begin
        d2_r[k] <= d2_r[k-1];
      end
    end
  end

  // back end: n x u, dot products with eye, rounding and saturation
  always_ff @(posedge clk) begin
    fx_t [2:0] eye;
    nv_t [2:0] n;
    eye = d2_r[UNIT_LAT-1].eye;
    n   = d2_r[UNIT_LAT-1].n;
    if (en) begin
      // Y1: products
      y1_va_r[0] <= VP_W'(signed'(n[1])) * VP_W'(signed'(u2_vec[2]));
      y1_vb_r[0] <= VP_W'(signed'(n[2])) * VP_W'(signed'(u2_vec[1]));
      y1_va_r[1] <= VP_W'(signed'(n[2])) * VP_W'(signed'(u2_vec[0]));
      y1_vb_r[1] <= VP_W'(signed'(n[0])) * VP_W'(signed'(u2_vec[2]));
      y1_va_r[2] <= VP_W'(signed'(n[0])) * VP_W'(signed'(u2_vec[1]));
      y1_vb_r[2] <= VP_W'(signed'(n[1])) * VP_W'(signed'(u2_vec[0]));
      for (int i = 0; i < 3; i++) begin
        y1_eu_r[i]  <= PN_W'(signed'(eye[i])) * PN_W'(signed'(u2_vec[i]));
        y1_enp_r[i] <= PN_W'(signed'(eye[i])) * PN_W'(signed'(n[i]));
      end
      y1_eye_r <= eye;
      y1_u_r   <= u2_vec;
      y1_n_r   <= n;
      y1_deg_r <= d2_r[UNIT_LAT-1].deg || u2_zero;

      // Y2: v rounded, dot sums for u and n
      for (int i = 0; i < 3; i++) begin
        y2_vv_r[i] <= round_v(VC_W'(y1_va_r[i]) - VC_W'(y1_vb_r[i]));
      end
      y2_du_r  <= D_W'(y1_eu_r[0]) + D_W'(y1_eu_r[1]) + D_W'(y1_eu_r[2]);
      y2_dn_r  <= D_W'(y1_enp_r[0]) + D_W'(y1_enp_r[1]) + D_W'(y1_enp_r[2]);
      y2_eye_r <= y1_eye_r;
      y2_u_r   <= y1_u_r;
      y2_n_r   <= y1_n_r;
      y2_deg_r <= y1_deg_r;

      // Y3: eye times v, translations of u and n
      for (int i = 0; i < 3; i++) begin
        y3_ev_r[i] <= EV_W'(signed'(y2_eye_r[i])) * EV_W'(signed'(y2_vv_r[i]));
      end
      y3_tu_r  <= neg_round_sat(y2_du_r);
      y3_tn_r  <= neg_round_sat(y2_dn_r);
      y3_u_r   <= y2_u_r;
      y3_n_r   <= y2_n_r;
      y3_vv_r  <= y2_vv_r;
      y3_deg_r <= y2_deg_r;

      // Y4: dot sum for v
      y4_dv_r  <= D_W'(y3_ev_r[0]) + D_W'(y3_ev_r[1]) + D_W'(y3_ev_r[2]);
      y4_tu_r  <= y3_tu_r;
      y4_tn_r  <= y3_tn_r;
      y4_u_r   <= y3_u_r;
      y4_n_r   <= y3_n_r;
      y4_vv_r  <= y3_vv_r;
      y4_deg_r <= y3_deg_r;

      // Y5: translation of v
      y5_tv_r  <= neg_round_sat(y4_dv_r);
      y5_tu_r  <= y4_tu_r;
      y5_tn_r  <= y4_tn_r;
      y5_u_r   <= y4_u_r;
      y5_n_r   <= y4_n_r;
      y5_vv_r  <= y4_vv_r;
      y5_deg_r <= y4_deg_r;
    end
  end

  always_comb begin
    rows.u   = y5_u_r;
    rows.v   = y5_vv_r;
    rows.n   = y5_n_r;
    rows.t   = {y5_tn_r, y5_tv_r, y5_tu_r};
    rows.deg = y5_deg_r;
  end

  lav_rowser u_rowser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (y5_v_r),
    .in_rows        (rows),
    .take           (en),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_index  (out_row_index),
    .out_col_0      (out_col_0),
    .out_col_1      (out_col_1),
    .out_col_2      (out_col_2),
    .out_col_3      (out_col_3),
    .out_last_row   (out_last_row),
    .out_degenerate (out_degenerate)
  );

  // checks on row sequencing and input flow
  `LAV_ASSERT_NXT(a_row_step, out_valid && !out_stall && (out_row_index != ROW_LAST), out_valid && (out_row_index == 2'($past(out_row_index) + 2'd1)), "row did not advance")
  `LAV_ASSERT_NXT(a_row_wrap, out_valid && !out_stall && (out_row_index == ROW_LAST), !out_valid || (out_row_index == ROW_U), "new item did not start at row 0")
  `LAV_ASSERT_IMP(a_idle_open, !out_valid, !in_stall, "input stalled with empty output")
  `LAV_ASSERT_IMP(a_last_flag, out_valid, out_last_row == (out_row_index == ROW_LAST), "last row flag mismatch")

endmodule

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// tb: look_at_view_matrix testbench
// Feeds camera setups (eye, target, up) through the view matrix pipeline and
// checks every emitted row against an in-bench fixed point predictor. Starts
// with a directed table, then random setups, with random stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lav_pkg::*;

  localparam int   NUM_RAND = 120;
  localparam int   NUM_DIR  = 10;
  localparam int   QUIET_AT = NUM_DIR + NUM_RAND - 20;
  localparam fx_t  FX_ONE   = 32'sh0001_0000;
  localparam fx_t  FX_MAX   = 32'sh7fff_ffff;
  localparam fx_t  FX_MIN   = 32'sh8000_0000;

  typedef struct {
    logic [1:0] row;
    fx_t        c0, c1, c2, c3;
    logic       last, degen;
  } view_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fx_t  in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  fx_t  in_target_x = '0, in_target_y = '0, in_target_z = '0;
  fx_t  in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_row_index;
  fx_t  out_col_0, out_col_1, out_col_2, out_col_3;
  logic out_last_row, out_degenerate;

  view_row_t pending_rows[$];
  int        mismatches = 0;
  int        rows_seen = 0;
  int        degen_setups = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  fx_t dir_tab [0:NUM_DIR-1][0:8];
  bit  dir_deg [0:NUM_DIR-1];

  always #4 clk = ~clk;

  look_at_view_matrix uut (.*);

  // ---- predictor -----------------------------------------------------------
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag_of(input longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  // Round x / 2^16 to nearest, ties away from zero
  function automatic longint round_q(input longint x);
    longint unsigned m;
    m = (mag_of(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Normalize to a unit vector; return 0 for the zero vector
  function automatic bit normalize(input longint c[3], output longint o[3]);
    longint unsigned m[3], mx, sum, nrm;
    mx = 0;
    sum = 0;
    o = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      m[i] = mag_of(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    nrm = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(((m[i] << FRAC_BITS) + (nrm >> 1)) / nrm);
      if (c[i] < 0) o[i] = -o[i];
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic fx_t neg_dot(input longint e[3], input longint r[3]);
    longint d;
    d = -round_q(e[0] * r[0] + e[1] * r[1] + e[2] * r[2]);
    if (d > longint'(FX_MAX)) d = longint'(FX_MAX);
    if (d < longint'(FX_MIN)) d = longint'(FX_MIN);
    return fx_t'(d);
  endfunction

  function automatic void push_row(input logic [1:0] r, input fx_t a, b, c, d,
                                   input logic dg);
    view_row_t x;
    x = '{r, a, b, c, d, r == ROW_LAST, dg};
    pending_rows.push_back(x);
  endfunction

  // Fixed rows of a degenerate camera setup
  function automatic void push_degenerate();
    push_row(ROW_U, 0, 0, 0, 0, 1'b1);
    push_row(ROW_V, 0, 0, 0, 0, 1'b1);
    push_row(ROW_N, 0, 0, 0, 0, 1'b1);
    push_row(ROW_LAST, 0, 0, 0, FX_ONE, 1'b1);
  endfunction

  function automatic void predict_view(input fx_t v[9]);
    longint eye[3], dv[3], up[3], n[3], c[3], u[3], vv[3];
    bit dg;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'(v[i]);
      dv[i]  = eye[i] - longint'(v[3+i]);
      up[i]  = longint'(v[6+i]);
    end
    dg = !normalize(dv, n);
    if (!dg) begin
      cross3(up, n, c);
      dg = !normalize(c, u);
    end
    if (dg) begin
      push_degenerate();
      return;
    end
    cross3(n, u, c);
    for (int i = 0; i < 3; i++) vv[i] = round_q(c[i]);
    push_row(ROW_U, fx_t'(u[0]), fx_t'(u[1]), fx_t'(u[2]), neg_dot(eye, u), 1'b0);
    push_row(ROW_V, fx_t'(vv[0]), fx_t'(vv[1]), fx_t'(vv[2]), neg_dot(eye, vv), 1'b0);
    push_row(ROW_N, fx_t'(n[0]), fx_t'(n[1]), fx_t'(n[2]), neg_dot(eye, n), 1'b0);
    push_row(ROW_LAST, 0, 0, 0, FX_ONE, 1'b0);
  endfunction

  // ---- checking ------------------------------------------------------------
  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    view_row_t w;
    if (rst_n && out_valid && !out_stall) begin
      rows_seen++;
      if (pending_rows.size() == 0) begin
        report("unexpected row, index", out_row_index, -1);
      end else begin
        w = pending_rows.pop_front();
        if (out_row_index !== w.row) report("row_index", out_row_index, w.row);
        if (out_col_0 !== w.c0) report("col_0", out_col_0, w.c0);
        if (out_col_1 !== w.c1) report("col_1", out_col_1, w.c1);
        if (out_col_2 !== w.c2) report("col_2", out_col_2, w.c2);
        if (out_col_3 !== w.c3) report("col_3", out_col_3, w.c3);
        if (out_last_row !== w.last) report("last_row", out_last_row, w.last);
        if (out_degenerate !== w.degen) report("degenerate", out_degenerate, w.degen);
      end
    end
  end

  // ---- receiver: random stall bursts, one long hold-off on request ---------
  initial begin
    int hold_cnt;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < 300; hold_cnt++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // ---- stimulus ------------------------------------------------------------
  function automatic fx_t rnd_span(input int bits);
    return fx_t'($signed($urandom) >>> (32 - bits));
  endfunction

  function automatic void random_setup(output fx_t v[9]);
    int kind;
    fx_t k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) v[i] = fx_t'($urandom);
    case (kind)
      0: begin
        // eye on top of target
        for (int i = 0; i < 3; i++) v[3+i] = v[i];
      end
      1: begin
        // up along the view direction
        k = fx_t'($urandom_range(1, 3));
        for (int i = 0; i < 3; i++) begin
          v[3+i] = rnd_span(24);
          v[i]   = v[3+i] + rnd_span(12);
          v[6+i] = (v[i] - v[3+i]) * k;
        end
      end
      2, 3: ;
      default: begin
        for (int i = 0; i < 6; i++) v[i] = rnd_span(25);
        for (int i = 6; i < 9; i++) v[i] = rnd_span(21);
      end
    endcase
  endfunction

  task automatic offer(input fx_t v[9]);
    in_eye_x <= v[0];  in_eye_y <= v[1];  in_eye_z <= v[2];
    in_target_x <= v[3];  in_target_y <= v[4];  in_target_z <= v[5];
    in_up_x <= v[6];  in_up_y <= v[7];  in_up_z <= v[8];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    fx_t v[9];
    int  drain;
    dir_tab = '{
      '{0, 0, 5 * FX_ONE, 0, 0, 0, 0, FX_ONE, 0},
      '{FX_ONE, 2 * FX_ONE, 3 * FX_ONE, FX_ONE, 2 * FX_ONE, 3 * FX_ONE, 0, FX_ONE, 0},
      '{FX_ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, FX_ONE, 0, 0, 0, 0, 0, 3 * FX_ONE},
      '{FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MAX, 0},
      '{FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, 1, 0, 0},
      '{FX_MAX, FX_MIN, FX_MAX, 0, 0, 0, FX_MAX, FX_MAX, FX_MIN},
      '{-1, -1, -1, 0, 0, 0, 0, FX_MAX, 0},
      '{0, 0, 0, 0, 0, 0, 0, FX_ONE, 0},
      '{FX_MIN, FX_MAX, 1, -1, FX_MIN, FX_MAX, FX_MIN, FX_MIN, FX_MIN}
    };
    dir_deg = '{0, 1, 1, 1, 0, 0, 0, 0, 1, 0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int t = 0; t < NUM_DIR + NUM_RAND; t++) begin
      if (t < NUM_DIR) v = dir_tab[t];
      else random_setup(v);
      if (t == 40) hold_req = 1'b1;
      if (t == 70) begin
        // pause until the pipeline has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0) @(posedge clk);
      end
      quiet = (t >= QUIET_AT);
      if (!quiet && t != 40 && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      offer(v);
      // record the transaction just accepted
      if (t < NUM_DIR && dir_deg[t]) push_degenerate();
      else predict_view(v);
      if (pending_rows[pending_rows.size()-1].degen) degen_setups++;
    end
    in_valid <= 1'b0;

    while (pending_rows.size() != 0) @(posedge clk);
    for (drain = 0; drain < 100; drain++) @(posedge clk);

    $display("Covered %0d camera setups (%0d degenerate), %0d rows checked,",
             NUM_DIR + NUM_RAND, degen_setups, rows_seen);
    $display("with random stalls, a long output hold-off and a full drain pause.");
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---- watchdog ------------------------------------------------------------
  initial begin
    #2000000;
    $display("timeout with %0d rows outstanding", pending_rows.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
